>>> hw/rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator core.
// State encoding, operation codes, register index and parameter defaults.
// No dependencies.
package bpa_pkg;

    // Parameter defaults
    localparam int MAX_PAGES_DEF  = 4096;
    localparam int TOP_ORDER_DEF  = 10;
    localparam int PAGE_BYTES_DEF = 4096;

    // Bytes added to every allocate request for the block header
    localparam int HDR_BYTES = 4;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REBUILD = 2'd2;
    // Spare code: changes nothing, answered with ok low
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Configuration register indexes (word addresses)
    localparam logic REG_POOL_PAGES = 1'b0;

    // Reset value of the pool size register
    localparam logic [12:0] POOL_PAGES_RST = 13'd4096;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_UNL,
        ST_ALLOC_SPLIT,
        ST_ALLOC_ADV,
        ST_FREE_CHK,
        ST_MERGE,
        ST_BUD_CHK,
        ST_UNL_PREV,
        ST_UNL_NEXT,
        ST_UNL_ORD,
        ST_PUSH,
        ST_PUSH_LINK,
        ST_CARVE,
        ST_CARVE_ADV,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/buddy_page_allocator_core.sv
// Buddy page allocator core: free lists kept as linked lists in on-chip memory.
// Depends on bpa_pkg for state encoding, operation codes and defaults.
//
// Usage:
//   Input stream (s_*): s_tuser carries the operation (allocate, free, rebuild),
//   s_tdata the byte size and the page to free. One result transaction leaves on
//   the m_* stream for every input transaction: ok flag in m_tuser, start page,
//   order and remaining free pages in m_tdata.
//   The pool size register sits on the APB port at address 0; write it only
//   while the core is idle. The core itself does not enforce this.
//   An allocate splits the chosen block down to the wanted order, a free merges
//   the block with free buddies of equal order, and a rebuild clears the
//   free-flag memory and then carves the pool into blocks.
//   The link memory has a single write port that takes one link update per cycle.
//   One operation is in flight at a time; s_tready is high while idle, even if a
//   finished result still waits on m_*.
//   Reset: the core runs a clearing pass over the free-flag memory and accepts
//   nothing meanwhile; afterwards all free lists are empty until a rebuild is
//   requested.
//   Stall: a result held by a low m_tready stops the core before its next result.
module buddy_page_allocator_core #(
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // alloc_bytes[23:0], free_page[35:24], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // page_index[11:0], block_order[15:12], free_count[28:16]
    output logic        m_tuser,   // ok[0]
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW   = $clog2(MAX_PAGES);
    localparam int LW   = $clog2(MAX_PAGES + 1);
    localparam int OW   = $clog2(TOP_ORDER + 1);
    localparam int NORD = TOP_ORDER + 1;
    localparam logic [LW-1:0] NONE = LW'(MAX_PAGES);
    localparam logic [OW-1:0] TOP  = OW'(TOP_ORDER);

    typedef struct packed {
        logic [OW-1:0] ord;
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
    } node_t;

    typedef struct packed {
        logic          we_ord;
        logic          we_prev;
        logic          we_next;
        logic [PW-1:0] addr;
        node_t         data;
    } node_wr_t;

    // Configuration
    logic [12:0] pool_pages_reg;
    logic        cfg_wr;
    logic [LW-1:0] pool;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == bpa_pkg::REG_POOL_PAGES) ? {19'd0, pool_pages_reg} : 32'd0;
    assign pool   = (32'(pool_pages_reg) > MAX_PAGES) ? NONE : LW'(pool_pages_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_pages_reg <= bpa_pkg::POOL_PAGES_RST;
        end else if (cfg_wr && paddr[2] == bpa_pkg::REG_POOL_PAGES) begin
            pool_pages_reg <= pwdata[12:0];
        end
    end

    // Link memory and free-flag memory
    node_t    node_mem [MAX_PAGES];
    logic     flag_mem [MAX_PAGES];
    node_t    node_q;
    logic     flag_q;
    node_wr_t node_wr;
    logic [PW-1:0] rd_addr;
    logic          flag_we;
    logic [PW-1:0] flag_wa;
    logic          flag_wd;

    always_ff @(posedge aclk) begin
        if (node_wr.we_ord) begin
            node_mem[node_wr.addr].ord <= node_wr.data.ord;
        end
        if (node_wr.we_prev) begin
            node_mem[node_wr.addr].prev <= node_wr.data.prev;
        end
        if (node_wr.we_next) begin
            node_mem[node_wr.addr].next <= node_wr.data.next;
        end
        node_q <= node_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_wa] <= flag_wd;
        end
        flag_q <= flag_mem[rd_addr];
    end

    // Control and working registers
    bpa_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [LW-1:0] head_reg [NORD];
    logic [LW-1:0] head_next [NORD];
    logic [LW-1:0] pg_reg, pg_next;
    logic [LW-1:0] bud_reg, bud_next;
    logic [LW-1:0] h_reg, h_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] n_reg, n_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [OW-1:0] want_reg, want_next;
    logic [LW-1:0] free_total_reg, free_total_next;
    logic [PW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_rebuild_reg, clr_rebuild_next;
    logic          res_ok_reg, res_ok_next;
    logic [LW-1:0] res_page_reg, res_page_next;
    logic [OW-1:0] res_ord_reg, res_ord_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    // Size-to-order fit and list occupancy
    logic [24:0]    need;
    logic [NORD-1:0] fit, nonempty, avail;
    logic [OW-1:0]  want_w, cur_w;
    logic [LW-1:0]  bud_w;
    logic [31:0]    step_w;

    assign need = 25'(s_tdata[23:0]) + 25'(bpa_pkg::HDR_BYTES);

    always_comb begin
        want_w = '0;
        cur_w  = '0;
        for (int r = NORD - 1; r >= 0; r--) begin
            fit[r]      = ((64'(PAGE_BYTES) << r) >= 64'(need));
            nonempty[r] = (head_reg[r] != NONE);
            avail[r]    = fit[r] & nonempty[r];
            if (fit[r]) begin
                want_w = OW'(r);
            end
            if (avail[r]) begin
                cur_w = OW'(r);
            end
        end
    end

    assign step_w = 32'd1 << ord_reg;
    assign bud_w  = pg_reg ^ LW'(step_w);

    assign s_tready = (state_reg == bpa_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Register update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bpa_pkg::ST_CLEAR;
            ret_reg         <= bpa_pkg::ST_DONE;
            clr_cnt_reg     <= '0;
            clr_rebuild_reg <= 1'b0;
            free_total_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < NORD; i++) begin
                head_reg[i] <= NONE;
            end
        end else begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_rebuild_reg <= clr_rebuild_next;
            free_total_reg  <= free_total_next;
            m_tvalid_reg    <= m_tvalid_next;
            for (int i = 0; i < NORD; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
        pg_reg       <= pg_next;
        bud_reg      <= bud_next;
        h_reg        <= h_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        ord_reg      <= ord_next;
        want_reg     <= want_next;
        res_ok_reg   <= res_ok_next;
        res_page_reg <= res_page_next;
        res_ord_reg  <= res_ord_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Next state, memory accesses and results
    always_comb begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        head_next        = head_reg;
        pg_next          = pg_reg;
        bud_next         = bud_reg;
        h_next           = h_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        ord_next         = ord_reg;
        want_next        = want_reg;
        free_total_next  = free_total_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_rebuild_next = clr_rebuild_reg;
        res_ok_next      = res_ok_reg;
        res_page_next    = res_page_reg;
        res_ord_next     = res_ord_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        rd_addr          = pg_reg[PW-1:0];
        node_wr          = '0;
        node_wr.addr     = pg_reg[PW-1:0];
        flag_we          = 1'b0;
        flag_wa          = pg_reg[PW-1:0];
        flag_wd          = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            // Sweep the free flags to zero
            bpa_pkg::ST_CLEAR: begin
                flag_we      = 1'b1;
                flag_wa      = clr_cnt_reg;
                flag_wd      = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == MAX_PAGES - 1) begin
                    clr_cnt_next = '0;
                    if (clr_rebuild_reg) begin
                        ord_next   = TOP;
                        pg_next    = '0;
                        state_next = bpa_pkg::ST_CARVE;
                    end else begin
                        state_next = bpa_pkg::ST_IDLE;
                    end
                end
            end

            bpa_pkg::ST_IDLE: begin
                res_ok_next   = 1'b0;
                res_page_next = '0;
                res_ord_next  = '0;
                pg_next       = LW'(s_tdata[35:24]);
                rd_addr       = PW'(s_tdata[35:24]);
                if (s_tvalid) begin
                    case (s_tuser)
                        bpa_pkg::OP_ALLOC: begin
                            want_next = want_w;
                            ord_next  = cur_w;
                            if (avail != '0) begin
                                state_next = bpa_pkg::ST_ALLOC_RD;
                            end else begin
                                state_next = bpa_pkg::ST_DONE;
                            end
                        end
                        bpa_pkg::OP_FREE: begin
                            state_next = bpa_pkg::ST_FREE_CHK;
                        end
                        bpa_pkg::OP_REBUILD: begin
                            for (int i = 0; i < NORD; i++) begin
                                head_next[i] = NONE;
                            end
                            clr_cnt_next     = '0;
                            clr_rebuild_next = 1'b1;
                            state_next       = bpa_pkg::ST_CLEAR;
                        end
                        default: begin
                            state_next = bpa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Pop the head of the chosen list
            bpa_pkg::ST_ALLOC_RD: begin
                pg_next    = head_reg[ord_reg];
                rd_addr    = head_reg[ord_reg][PW-1:0];
                state_next = bpa_pkg::ST_ALLOC_UNL;
            end

            bpa_pkg::ST_ALLOC_UNL: begin
                head_next[ord_reg] = node_q.next;
                flag_we            = 1'b1;
                flag_wd            = 1'b0;
                if (node_q.next != NONE) begin
                    node_wr.we_prev   = 1'b1;
                    node_wr.addr      = node_q.next[PW-1:0];
                    node_wr.data.prev = NONE;
                end
                state_next = bpa_pkg::ST_ALLOC_SPLIT;
            end

            // Push lower halves back, keep the upper half
            bpa_pkg::ST_ALLOC_SPLIT: begin
                if (ord_reg > want_reg) begin
                    ord_next   = ord_reg - 1'b1;
                    ret_next   = bpa_pkg::ST_ALLOC_ADV;
                    state_next = bpa_pkg::ST_PUSH;
                end else begin
                    if (32'(pg_reg) < MAX_PAGES) begin
                        node_wr.we_ord   = 1'b1;
                        node_wr.data.ord = want_reg;
                        flag_we          = 1'b1;
                        flag_wd          = 1'b0;
                    end
                    free_total_next = (32'(free_total_reg) > step_w) ?
                                      LW'(32'(free_total_reg) - step_w) : '0;
                    res_ok_next     = 1'b1;
                    res_page_next   = pg_reg;
                    res_ord_next    = want_reg;
                    state_next      = bpa_pkg::ST_DONE;
                end
            end

            bpa_pkg::ST_ALLOC_ADV: begin
                pg_next    = pg_reg + LW'(step_w);
                state_next = bpa_pkg::ST_ALLOC_SPLIT;
            end

            // Check the block being freed
            bpa_pkg::ST_FREE_CHK: begin
                if (pg_reg >= pool || flag_q) begin
                    state_next = bpa_pkg::ST_DONE;
                end else begin
                    if (node_q.ord > TOP) begin
                        ord_next = TOP;
                    end else begin
                        ord_next = node_q.ord;
                    end
                    if (32'(free_total_reg) + (32'd1 << ord_next) > MAX_PAGES) begin
                        free_total_next = NONE;
                    end else begin
                        free_total_next = LW'(32'(free_total_reg) + (32'd1 << ord_next));
                    end
                    state_next = bpa_pkg::ST_MERGE;
                end
            end

            // Look at the buddy of the current block
            bpa_pkg::ST_MERGE: begin
                bud_next = bud_w;
                rd_addr  = bud_w[PW-1:0];
                if (ord_reg < TOP && bud_w < pool) begin
                    state_next = bpa_pkg::ST_BUD_CHK;
                end else begin
                    res_ok_next   = 1'b1;
                    res_page_next = pg_reg;
                    res_ord_next  = ord_reg;
                    ret_next      = bpa_pkg::ST_DONE;
                    state_next    = bpa_pkg::ST_PUSH;
                end
            end

            bpa_pkg::ST_BUD_CHK: begin
                if (!flag_q || node_q.ord != ord_reg) begin
                    res_ok_next   = 1'b1;
                    res_page_next = pg_reg;
                    res_ord_next  = ord_reg;
                    ret_next      = bpa_pkg::ST_DONE;
                    state_next    = bpa_pkg::ST_PUSH;
                end else begin
                    p_next     = node_q.prev;
                    n_next     = node_q.next;
                    state_next = bpa_pkg::ST_UNL_PREV;
                end
            end

            // Unlink the buddy from its list
            bpa_pkg::ST_UNL_PREV: begin
                if (p_reg != NONE) begin
                    node_wr.we_next   = 1'b1;
                    node_wr.addr      = p_reg[PW-1:0];
                    node_wr.data.next = n_reg;
                end else begin
                    head_next[ord_reg] = n_reg;
                end
                state_next = bpa_pkg::ST_UNL_NEXT;
            end

            bpa_pkg::ST_UNL_NEXT: begin
                if (n_reg != NONE) begin
                    node_wr.we_prev   = 1'b1;
                    node_wr.addr      = n_reg[PW-1:0];
                    node_wr.data.prev = p_reg;
                end
                flag_we    = 1'b1;
                flag_wa    = bud_reg[PW-1:0];
                flag_wd    = 1'b0;
                state_next = bpa_pkg::ST_UNL_ORD;
            end

            bpa_pkg::ST_UNL_ORD: begin
                node_wr.we_ord   = 1'b1;
                node_wr.addr     = bud_reg[PW-1:0];
                node_wr.data.ord = '0;
                pg_next          = pg_reg & bud_reg;
                ord_next         = ord_reg + 1'b1;
                state_next       = bpa_pkg::ST_MERGE;
            end

            // Push block pg at order ord onto the head of its list
            bpa_pkg::ST_PUSH: begin
                node_wr.we_ord     = 1'b1;
                node_wr.we_prev    = 1'b1;
                node_wr.we_next    = 1'b1;
                node_wr.data.ord   = ord_reg;
                node_wr.data.prev  = NONE;
                node_wr.data.next  = head_reg[ord_reg];
                flag_we            = 1'b1;
                flag_wd            = 1'b1;
                h_next             = head_reg[ord_reg];
                head_next[ord_reg] = pg_reg;
                state_next         = bpa_pkg::ST_PUSH_LINK;
            end

            bpa_pkg::ST_PUSH_LINK: begin
                if (h_reg != NONE) begin
                    node_wr.we_prev   = 1'b1;
                    node_wr.addr      = h_reg[PW-1:0];
                    node_wr.data.prev = pg_reg;
                end
                state_next = ret_reg;
            end

            // Carve the pool into the largest aligned blocks
            bpa_pkg::ST_CARVE: begin
                if (32'(pg_reg) + step_w <= 32'(pool)) begin
                    ret_next   = bpa_pkg::ST_CARVE_ADV;
                    state_next = bpa_pkg::ST_PUSH;
                end else if (ord_reg == '0) begin
                    free_total_next  = pool;
                    clr_rebuild_next = 1'b0;
                    res_ok_next      = 1'b1;
                    res_page_next    = '0;
                    res_ord_next     = '0;
                    state_next       = bpa_pkg::ST_DONE;
                end else begin
                    ord_next = ord_reg - 1'b1;
                end
            end

            bpa_pkg::ST_CARVE_ADV: begin
                pg_next    = pg_reg + LW'(step_w);
                state_next = bpa_pkg::ST_CARVE;
            end

            // Hand the result to the output register
            bpa_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_ok_reg;
                    m_tdata_next  = {3'd0, 13'(free_total_reg), 4'(res_ord_reg),
                                     12'(res_page_reg)};
                    state_next    = bpa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> bench/buddy_page_allocator_checker.sv
// Checker for the buddy page allocator core: watches the input, result and APB channels,
// predicts every result from its own copy of the free lists and compares field by field.
// Depends on bpa_pkg for the operation codes and the register index.
`timescale 1ns / 100ps

module buddy_page_allocator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // alloc_bytes[23:0], free_page[35:24], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // page_index[11:0], block_order[15:12], free_count[28:16]
    input  logic        m_tuser,   // ok[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    localparam int PAGES = bpa_pkg::MAX_PAGES_DEF;
    localparam int TOPO  = bpa_pkg::TOP_ORDER_DEF;
    localparam logic [12:0] NO_PAGE = 13'(PAGES);

    typedef struct packed {
        logic        ok;
        logic [11:0] page;
        logic [3:0]  order;
        logic [12:0] pages_left;
    } block_result_t;

    // Shadow allocator state
    logic [12:0]   head_of[TOPO+1];
    int            blocks_in[TOPO+1];
    logic [12:0]   link_next[PAGES];
    logic [12:0]   link_prev[PAGES];
    logic [3:0]    order_at[PAGES];
    bit            is_free[PAGES];
    int            pages_free;
    int            pool_limit;
    block_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic void list_push(int ord, int pg);
        logic [12:0] h;
        h = head_of[ord];
        link_next[pg] = h;
        link_prev[pg] = NO_PAGE;
        if (h < NO_PAGE) link_prev[h] = 13'(pg);
        head_of[ord] = 13'(pg);
        is_free[pg] = 1'b1;
        blocks_in[ord]++;
    endfunction

    function automatic void list_remove(int ord, int pg);
        logic [12:0] p, n;
        p = link_prev[pg];
        n = link_next[pg];
        if (p < NO_PAGE) link_next[p] = n;
        else head_of[ord] = n;
        if (n < NO_PAGE) link_prev[n] = p;
        is_free[pg] = 1'b0;
        if (blocks_in[ord] > 0) blocks_in[ord]--;
    endfunction

    function automatic block_result_t predict_allocator(logic [1:0] op, int bytes, int fpage);
        block_result_t res;
        int pool, cur, ord, want, pg, idx, bud, sz;
        longint need;
        res = '0;
        pool = (pool_limit > PAGES) ? PAGES : pool_limit;
        case (op)
            bpa_pkg::OP_REBUILD: begin
                for (int i = 0; i <= TOPO; i++) begin
                    head_of[i] = NO_PAGE;
                    blocks_in[i] = 0;
                end
                for (int i = 0; i < PAGES; i++) is_free[i] = 1'b0;
                cur = 0;
                for (ord = TOPO; ord >= 0; ord--) begin
                    sz = 1 << ord;
                    while (cur + sz <= pool) begin
                        order_at[cur] = 4'(ord);
                        list_push(ord, cur);
                        cur += sz;
                    end
                end
                pages_free = pool;
                res.ok = 1'b1;
            end
            bpa_pkg::OP_ALLOC: begin
                need = longint'(bytes) + bpa_pkg::HDR_BYTES;
                want = TOPO + 1;
                for (int r = 0; r <= TOPO; r++)
                    if ((longint'(bpa_pkg::PAGE_BYTES_DEF) << r) >= need) begin
                        want = r;
                        break;
                    end
                if (want <= TOPO) begin
                    for (cur = want; cur <= TOPO; cur++)
                        if (head_of[cur] < NO_PAGE) break;
                    if (cur <= TOPO) begin
                        pg = head_of[cur];
                        list_remove(cur, pg);
                        // split: lower halves go back, upper half is kept
                        while (cur > want) begin
                            cur--;
                            order_at[pg] = 4'(cur);
                            list_push(cur, pg);
                            pg += 1 << cur;
                        end
                        order_at[pg] = 4'(want);
                        is_free[pg] = 1'b0;
                        pages_free = (pages_free > (1 << want)) ? pages_free - (1 << want) : 0;
                        res.ok = 1'b1;
                        res.page = 12'(pg);
                        res.order = 4'(want);
                    end
                end
            end
            bpa_pkg::OP_FREE: begin
                if (fpage < pool && !is_free[fpage]) begin
                    ord = order_at[fpage];
                    if (ord > TOPO) ord = TOPO;
                    idx = fpage;
                    pages_free += 1 << ord;
                    if (pages_free > PAGES) pages_free = PAGES;
                    // merge with free buddies of equal order
                    while (ord < TOPO) begin
                        bud = idx ^ (1 << ord);
                        if (bud >= pool || !is_free[bud] || order_at[bud] != ord) break;
                        list_remove(ord, bud);
                        order_at[bud] = '0;
                        idx &= bud;
                        ord++;
                    end
                    order_at[idx] = 4'(ord);
                    list_push(ord, idx);
                    res.ok = 1'b1;
                    res.page = 12'(idx);
                    res.order = 4'(ord);
                end
            end
            default: ;
        endcase
        res.pages_left = 13'(pages_free);
        return res;
    endfunction

    always @(posedge aclk) begin
        block_result_t want_res, got;
        if (!aresetn) begin
            pool_limit = 32'(bpa_pkg::POOL_PAGES_RST);
            pages_free = 0;
            for (int i = 0; i <= TOPO; i++) begin
                head_of[i] = NO_PAGE;
                blocks_in[i] = 0;
            end
            for (int i = 0; i < PAGES; i++) begin
                is_free[i] = 1'b0;
                order_at[i] = '0;
            end
            expected_results.delete();
            fail_count = 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready &&
                paddr == {bpa_pkg::REG_POOL_PAGES, 2'b00})
                pool_limit = int'(pwdata[12:0]);
            // compare the result transaction with the oldest expectation
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[11:0], m_tdata[15:12], m_tdata[28:16]};
                if (expected_results.size() == 0) begin
                    $display("%t: unexpected result ok=%0d page=%0d order=%0d free=%0d",
                             $realtime, got.ok, got.page, got.order, got.pages_left);
                    fail_count++;
                end else begin
                    want_res = expected_results[0];
                    expected_results.delete(0);
                    if (got.ok !== want_res.ok) begin
                        $display("%t: ok expected %0d actual %0d", $realtime,
                                 want_res.ok, got.ok);
                        fail_count++;
                    end
                    if (got.page !== want_res.page) begin
                        $display("%t: page_index expected %0d actual %0d", $realtime,
                                 want_res.page, got.page);
                        fail_count++;
                    end
                    if (got.order !== want_res.order) begin
                        $display("%t: block_order expected %0d actual %0d", $realtime,
                                 want_res.order, got.order);
                        fail_count++;
                    end
                    if (got.pages_left !== want_res.pages_left) begin
                        $display("%t: free_count expected %0d actual %0d", $realtime,
                                 want_res.pages_left, got.pages_left);
                        fail_count++;
                    end
                end
            end
            // predict each accepted request
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_allocator(s_tuser, int'(s_tdata[23:0]),
                                                             int'(s_tdata[35:24])));
        end
    end

endmodule

>>> bench/buddy_page_allocator_core_test.sv
// Top of the buddy page allocator bench: clock, reset, APB writes and request stimulus.
// Depends on bpa_pkg, buddy_page_allocator_core and buddy_page_allocator_checker.
`timescale 1ns / 100ps

module buddy_page_allocator_core_test;

    localparam int STALL_LIMIT = 30000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // alloc_bytes[23:0], free_page[35:24], zero pad
    logic [1:0]  s_tuser = bpa_pkg::OP_ALLOC;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // page_index[11:0], block_order[15:12], free_count[28:16]
    logic        m_tuser;   // ok[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending;
    int send_gap_pct = 0, recv_stall_pct = 0, hold_left = 0;
    int quiet_cycles = 0, pool_now = 4096;

    // stimulus bookkeeping: ops in flight, blocks we own, pages with a stored order
    logic [1:0] ops_in_flight[$];
    int         owned_blocks[$];
    int         known_pages[$];
    bit         order_known[4096];

    buddy_page_allocator_core dut (.*);

    buddy_page_allocator_checker checker_i (.*);

    initial forever #2 aclk = ~aclk;

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // learn which pages are allocated or carry a written order
    always @(posedge aclk) begin
        logic [1:0] op;
        int pg;
        if (s_tvalid && s_tready) ops_in_flight.push_back(s_tuser);
        if (m_tvalid && m_tready && ops_in_flight.size() > 0) begin
            op = ops_in_flight[0];
            ops_in_flight.delete(0);
            pg = int'(m_tdata[11:0]);
            if (m_tuser && (op == bpa_pkg::OP_ALLOC || op == bpa_pkg::OP_FREE)) begin
                if (!order_known[pg]) begin
                    order_known[pg] = 1'b1;
                    known_pages.push_back(pg);
                end
                if (op == bpa_pkg::OP_ALLOC) owned_blocks.push_back(pg);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // issue one request; starts and ends at a falling edge
    task automatic send_request(logic [1:0] op, int bytes, int page);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, 12'(page), 24'(bytes)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // write the pool size while idle, then carve it
    task automatic set_pool(int pages);
        drain_results();
        repeat (80) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {bpa_pkg::REG_POOL_PAGES, 2'b00};
        pwdata  <= 32'(pages);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pool_now = pages;
        owned_blocks.delete();
        send_request(bpa_pkg::OP_REBUILD, 0, 0);
    endtask

    // byte count that lands mostly on small orders
    function automatic int pick_size();
        int roll, ord;
        roll = $urandom_range(0, 99);
        if (roll >= 98) return int'($urandom_range(0, 24'hFFFFFF));
        ord = roll < 50 ? 0 : roll < 75 ? $urandom_range(1, 3) :
              roll < 92 ? $urandom_range(4, 7) : $urandom_range(8, 10);
        return $urandom_range(ord == 0 ? 0 : (4096 << (ord - 1)) - 3, (4096 << ord) - 4);
    endfunction

    task automatic random_requests(int count);
        int roll, k, pg;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45 || (roll < 88 && known_pages.size() == 0)) begin
                send_request(bpa_pkg::OP_ALLOC, pick_size(), 0);
            end else if (roll < 88) begin
                // mostly release owned blocks, sometimes stale or outside pages
                k = $urandom_range(0, 99);
                if (k < 70 && owned_blocks.size() > 0) begin
                    pg = $urandom_range(0, owned_blocks.size() - 1);
                    send_request(bpa_pkg::OP_FREE, 0, owned_blocks[pg]);
                    owned_blocks.delete(pg);
                end else if (k < 80 && pool_now < 4096) begin
                    send_request(bpa_pkg::OP_FREE, 0, $urandom_range(pool_now, 4095));
                end else begin
                    pg = known_pages[$urandom_range(0, known_pages.size() - 1)];
                    send_request(bpa_pkg::OP_FREE, 0, pg);
                end
            end else if (roll < 90) begin
                send_request(bpa_pkg::OP_REBUILD, $urandom_range(0, 24'hFFFFFF), 0);
            end else begin
                send_request(bpa_pkg::OP_UNUSED, $urandom_range(0, 24'hFFFFFF),
                             $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        int pg;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty lists, size boundaries, double free
        send_request(bpa_pkg::OP_UNUSED, 24'hFFFFFF, 12'hFFF);
        send_request(bpa_pkg::OP_ALLOC, 0, 0);
        send_request(bpa_pkg::OP_REBUILD, 0, 0);
        send_request(bpa_pkg::OP_ALLOC, 0, 0);
        send_request(bpa_pkg::OP_ALLOC, 4092, 0);
        send_request(bpa_pkg::OP_ALLOC, 4093, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194300, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194301, 0);
        send_request(bpa_pkg::OP_ALLOC, 24'hFFFFFF, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194300, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194300, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194300, 0);
        send_request(bpa_pkg::OP_ALLOC, 4194300, 0);
        drain_results();
        @(negedge aclk);
        while (owned_blocks.size() > 0) begin
            pg = owned_blocks[0];
            owned_blocks.delete(0);
            send_request(bpa_pkg::OP_FREE, 0, pg);
            send_request(bpa_pkg::OP_FREE, 0, pg);
        end

        // random phases across pool sizes and idling patterns
        recv_stall_pct = 0;  send_gap_pct = 0;
        random_requests(120);
        set_pool(37);
        send_request(bpa_pkg::OP_FREE, 0, 4095);
        send_gap_pct = 63;   recv_stall_pct = 0;
        random_requests(120);
        set_pool(0);
        send_gap_pct = 0;    recv_stall_pct = 63;
        send_request(bpa_pkg::OP_ALLOC, 0, 0);
        random_requests(30);
        set_pool(1);
        random_requests(40);
        set_pool(4095);
        send_gap_pct = 7;    recv_stall_pct = 7;
        random_requests(150);

        // long receiver hold-off while requests keep coming
        set_pool(13);
        send_gap_pct = 0;    recv_stall_pct = 0;
        drain_results();
        hold_left = 400;
        random_requests(40);
        set_pool(1000);
        random_requests(100);
        set_pool(4096);
        send_gap_pct = 63;   recv_stall_pct = 63;
        random_requests(100);

        drain_results();
        repeat (100) @(negedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
